// ===== src/lcp_pkg.sv =====
// Shared types, codes and the grammar step function of the line command parser.
package lcp_pkg;

  localparam int unsigned MAX_LINE   = 4096;
  localparam int unsigned LINE_LEN_W = $clog2(MAX_LINE);

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_OPEN  = 8'h3C;
  localparam logic [7:0] CH_CLOSE = 8'h3E;

  typedef logic [3:0] phase_t;

  localparam phase_t PH_START     = 4'd0;
  localparam phase_t PH_G         = 4'd1;
  localparam phase_t PH_GE        = 4'd2;
  localparam phase_t PH_P         = 4'd3;
  localparam phase_t PH_PU        = 4'd4;
  localparam phase_t PH_GET_OPEN  = 4'd5;
  localparam phase_t PH_PUT_OPEN  = 4'd6;
  localparam phase_t PH_GET_NAME  = 4'd7;
  localparam phase_t PH_PUT_NAME  = 4'd8;
  localparam phase_t PH_CONT_OPEN = 4'd9;
  localparam phase_t PH_CONTENT   = 4'd10;
  localparam phase_t PH_GET_DONE  = 4'd11;
  localparam phase_t PH_PUT_DONE  = 4'd12;
  localparam phase_t PH_FAIL      = 4'd13;

  localparam logic [1:0] KIND_OTHER   = 2'd0;
  localparam logic [1:0] KIND_NAME    = 2'd1;
  localparam logic [1:0] KIND_CONTENT = 2'd2;
  localparam logic [1:0] KIND_END     = 2'd3;

  localparam logic [1:0] V_NONE = 2'd0;
  localparam logic [1:0] V_GET  = 2'd1;
  localparam logic [1:0] V_PUT  = 2'd2;
  localparam logic [1:0] V_ERR  = 2'd3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [1:0] verdict;
    logic       stream_closed;
  } result_t;

  typedef struct packed {
    phase_t     phase;
    logic [1:0] kind;
  } step_t;

  // Grammar transition for one byte that is not a newline.
  function automatic step_t advance(input phase_t ph, input logic [7:0] b);
    step_t s;
    s.kind  = KIND_OTHER;
    s.phase = PH_FAIL;
    case (ph)
      PH_START: begin
        if (b == CH_G) s.phase = PH_G;
        else if (b == CH_P) s.phase = PH_P;
      end
      PH_G:         if (b == CH_E) s.phase = PH_GE;
      PH_GE:        if (b == CH_T) s.phase = PH_GET_OPEN;
      PH_P:         if (b == CH_U) s.phase = PH_PU;
      PH_PU:        if (b == CH_T) s.phase = PH_PUT_OPEN;
      PH_GET_OPEN:  if (b == CH_OPEN) s.phase = PH_GET_NAME;
      PH_PUT_OPEN:  if (b == CH_OPEN) s.phase = PH_PUT_NAME;
      PH_CONT_OPEN: if (b == CH_OPEN) s.phase = PH_CONTENT;
      PH_GET_NAME: begin
        if (b == CH_CLOSE) s.phase = PH_GET_DONE;
        else begin
          s.phase = PH_GET_NAME;
          s.kind  = KIND_NAME;
        end
      end
      PH_PUT_NAME: begin
        if (b == CH_CLOSE) s.phase = PH_CONT_OPEN;
        else begin
          s.phase = PH_PUT_NAME;
          s.kind  = KIND_NAME;
        end
      end
      PH_CONTENT: begin
        if (b == CH_CLOSE) s.phase = PH_PUT_DONE;
        else begin
          s.phase = PH_CONTENT;
          s.kind  = KIND_CONTENT;
        end
      end
      PH_GET_DONE: s.phase = PH_GET_DONE;
      PH_PUT_DONE: s.phase = PH_PUT_DONE;
      default:     s.phase = PH_FAIL;
    endcase
    return s;
  endfunction

endpackage

// ===== src/lcp_out_buf.sv =====
// Output register with a skid stage for the result channel of the line command parser.
module lcp_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  lcp_pkg::result_t wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output lcp_pkg::result_t rd_data
);

  logic             main_valid_r, main_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  lcp_pkg::result_t main_r, main_nxt;
  lcp_pkg::result_t skid_r, skid_nxt;

  assign wr_ready = !skid_valid_r;
  assign rd_valid = main_valid_r;
  assign rd_data  = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (main_valid_r && rd_ready) begin
      main_valid_nxt = skid_valid_r;
      main_nxt       = skid_r;
      skid_valid_nxt = 1'b0;
    end
    if (wr_valid && !skid_valid_r) begin
      if (!main_valid_r || rd_ready) begin
        main_valid_nxt = 1'b1;
        main_nxt       = wr_data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// ===== src/line_command_parser.sv =====
// Top level of the line command parser: grammar state, line counter and result channel.
//
//   Channel | Direction | Ports                  | Word contents
//   in      | input     | in_tvalid/tready/tdata | tdata[7:0] byte of the stream
//   out     | output    | out_tvalid/tready/...  | tdata byte, verdict, closed; tuser kind
//
// Each accepted input word has its result written to the output register, or to
// the skid stage while the output is held, in the same cycle; one word per cycle is
// sustained while results are taken, set by the single step of the phase and length registers.
// Synchronous reset returns the parser to the start of a line with the stream open.
// A skid stage holds one further result, so input is refused only when two
// results wait for the consumer.
module line_command_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [9:8] verdict, [10] stream_closed
  output logic [1:0]  out_tuser   // [1:0] kind
);

  lcp_pkg::phase_t                    phase_r, phase_nxt;
  logic [lcp_pkg::LINE_LEN_W-1:0]     len_r, len_nxt;
  logic                               closed_r, closed_nxt;
  logic                               accept;
  lcp_pkg::step_t                     step;
  lcp_pkg::result_t                   res;
  lcp_pkg::result_t                   res_q;

  assign accept = in_tvalid && in_tready;
  assign step   = lcp_pkg::advance(phase_r, in_tdata);

  always_comb begin
    phase_nxt   = phase_r;
    len_nxt     = len_r;
    closed_nxt  = closed_r;
    res.out_byte = in_tdata;
    res.kind     = lcp_pkg::KIND_OTHER;
    res.verdict  = lcp_pkg::V_NONE;
    if (!closed_r) begin
      if (in_tdata == lcp_pkg::CH_NL) begin
        res.kind = lcp_pkg::KIND_END;
        if (phase_r == lcp_pkg::PH_GET_DONE) res.verdict = lcp_pkg::V_GET;
        else if (phase_r == lcp_pkg::PH_PUT_DONE) res.verdict = lcp_pkg::V_PUT;
        else res.verdict = lcp_pkg::V_ERR;
        phase_nxt = lcp_pkg::PH_START;
        len_nxt   = '0;
      end else if (len_r == lcp_pkg::LINE_LEN_W'(lcp_pkg::MAX_LINE - 1)) begin
        closed_nxt = 1'b1;
      end else begin
        len_nxt   = len_r + 1'b1;
        phase_nxt = step.phase;
        res.kind  = step.kind;
      end
    end
    res.stream_closed = closed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= lcp_pkg::PH_START;
      len_r    <= '0;
      closed_r <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      len_r    <= len_nxt;
      closed_r <= closed_nxt;
    end
  end

  lcp_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_tvalid),
    .wr_ready (in_tready),
    .wr_data  (res),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (res_q)
  );

  assign out_tdata = {5'd0, res_q.stream_closed, res_q.verdict, res_q.out_byte};
  assign out_tuser = res_q.kind;

endmodule
